/* rtl/core/h_bridge_pwm_motor_driver_unit_defines.svh */
// ----------------------------------------------------------------------------
// H-bridge PWM motor driver: assertion macros
// Shared assertion forms for the checker of the motor driver.
// ----------------------------------------------------------------------------
`ifndef H_BRIDGE_PWM_MOTOR_DRIVER_UNIT_DEFINES_SVH
`define H_BRIDGE_PWM_MOTOR_DRIVER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HBPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hbpm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HBPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hbpm assertion failed");

`endif

/* rtl/core/hbpm_pkg.sv */
// ----------------------------------------------------------------------------
// H-bridge PWM motor driver package
// Payload types, operation and register codes, and the motor ownership rule.
// ----------------------------------------------------------------------------
`default_nettype none

package hbpm_pkg;

    localparam int CNT_W     = 12;
    localparam int LIMIT_W   = 11;
    localparam int REQ_W     = 16;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int PINS_W    = 8;
    localparam int MAX_MOTORS = 4;

    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_SET_SPEED = 2'd1;
    localparam logic [1:0] OP_SET_DIR   = 2'd2;
    localparam logic [1:0] OP_RESERVED  = 2'd3;

    localparam logic [1:0] GANG_SEPARATE = 2'd0;
    localparam logic [1:0] GANG_PAIRS    = 2'd1;
    localparam logic [1:0] GANG_ALL      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GANG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 2'd2;

    localparam logic [CNT_W-1:0]   RESET_PERIOD = 12'd2016;
    localparam logic [LIMIT_W-1:0] RESET_LIMIT  = 11'd1000;

    typedef struct packed {
        logic [1:0]       operation;
        logic [1:0]       motor_index;
        logic [REQ_W-1:0] speed_request;
        logic             direction;
    } t_cmd;

    typedef struct packed {
        logic [PINS_W-1:0] bridge_pins;
        logic              accepted;
    } t_res;

    // True when channel ch drives motor k in the given gang mode.
    function automatic logic owns_motor(input logic [1:0] mode, input int ch, input int k);
        logic own;
        case (mode)
            GANG_PAIRS: own = ((k / 2) == ch);
            GANG_ALL:   own = (ch == 0);
            default:    own = (k == ch);
        endcase
        return own;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/hbpm_stream_if.sv */
// ----------------------------------------------------------------------------
// H-bridge PWM motor driver stream interface
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbpm_stream_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/h_bridge_pwm_motor_driver_unit.sv */
// Usage: commands arrive on i_cmd as valid/ready transfers. A tick advances
// the PWM period counter by one step; set-speed and set-direction commands
// update one channel. Every accepted command produces exactly one result on
// o_res with the bridge pin levels after the command and an accepted flag.
// The result is registered and becomes valid in the cycle after the input transfer.
// Throughput is one command per cycle unless o_res stalls; the state update
// and the result logic sit between the state registers and a single result
// register. When the receiver stalls, the result register holds its transfer
// and i_cmd.ready drops until the result is taken, so no command is lost.
// Configuration writes on i_cfg_we are registered; the user must make them only
// while no command is in flight, as the block does not enforce this.
// Synchronous reset clears the counter, speeds, directions, compare values
// and pins, loads the default period and limit, and empties the result
// register; i_cmd.ready stays low for the cycle after reset.
// ----------------------------------------------------------------------------
// H-bridge PWM motor driver top level
// Multi-channel PWM generator with ganging modes for H-bridge motor drivers.
// ----------------------------------------------------------------------------
`default_nettype none

module h_bridge_pwm_motor_driver_unit #(
    parameter int CHANNELS = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [hbpm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [hbpm_pkg::CFG_W-1:0]     i_cfg_data,
    hbpm_stream_if.sink                         i_cmd,
    hbpm_stream_if.source                       o_res
);

    localparam int MOTORS = (CHANNELS < hbpm_pkg::MAX_MOTORS) ? CHANNELS
                                                               : hbpm_pkg::MAX_MOTORS;
    localparam logic [3:0] ACT_SEPARATE = 4'(CHANNELS);
    localparam logic [3:0] ACT_PAIRS    = 4'((CHANNELS + 1) / 2);
    localparam logic [3:0] ACT_ALL      = 4'd1;

    logic [1:0]                       r_gang;
    logic [hbpm_pkg::CNT_W-1:0]       r_period;
    logic [hbpm_pkg::LIMIT_W-1:0]     r_limit;
    logic [hbpm_pkg::CNT_W-1:0]       r_count;
    logic [hbpm_pkg::CNT_W-1:0]       r_speed [CHANNELS];
    logic                             r_dir   [CHANNELS];
    logic [hbpm_pkg::CNT_W-1:0]       r_cmp   [CHANNELS];
    logic [hbpm_pkg::PINS_W-1:0]      r_pins;
    logic                             r_run;

    logic [hbpm_pkg::CNT_W-1:0]       n_count;
    logic [hbpm_pkg::CNT_W-1:0]       n_speed [CHANNELS];
    logic                             n_dir   [CHANNELS];
    logic [hbpm_pkg::CNT_W-1:0]       n_cmp   [CHANNELS];
    logic [hbpm_pkg::PINS_W-1:0]      n_pins;

    hbpm_pkg::t_cmd                   cmd;
    hbpm_pkg::t_res                   res;
    logic                             out_free;
    logic                             accept;
    logic                             wrap;
    logic                             ch_ok;
    logic [3:0]                       act;
    logic [hbpm_pkg::CNT_W-1:0]       tick_count;
    logic [1:0]                       motor_pins;

    assign cmd          = i_cmd.payload;
    assign i_cmd.ready  = r_run && out_free;
    assign accept       = i_cmd.valid && i_cmd.ready;

    always_comb begin
        unique case (r_gang)
            hbpm_pkg::GANG_PAIRS: act = ACT_PAIRS;
            hbpm_pkg::GANG_ALL:   act = ACT_ALL;
            default:              act = ACT_SEPARATE;
        endcase
    end

    assign ch_ok      = {2'b00, cmd.motor_index} < act;
    assign wrap       = r_count >= r_period;
    assign tick_count = wrap ? '0 : r_count + 1'b1;

    always_comb begin
        n_count    = r_count;
        n_pins     = r_pins;
        motor_pins = 2'b00;
        res.accepted = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            n_speed[c] = r_speed[c];
            n_dir[c]   = r_dir[c];
            n_cmp[c]   = r_cmp[c];
        end
        if (accept) begin
            unique case (cmd.operation)
                hbpm_pkg::OP_TICK: begin
                    res.accepted = 1'b1;
                    n_count      = tick_count;
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (wrap) begin
                            n_cmp[c] = r_speed[c];
                        end
                    end
                    for (int k = 0; k < MOTORS; k++) begin
                        motor_pins = r_pins[2*k +: 2];
                        for (int c = 0; c < CHANNELS; c++) begin
                            if (hbpm_pkg::owns_motor(r_gang, c, k)) begin
                                if (wrap) begin
                                    if (r_speed[c] == '0) begin
                                        motor_pins = 2'b00;
                                    end else begin
                                        motor_pins = r_dir[c] ? 2'b10 : 2'b01;
                                    end
                                end
                                if (tick_count == n_cmp[c]) begin
                                    motor_pins = 2'b00;
                                end
                            end
                        end
                        n_pins[2*k +: 2] = motor_pins;
                    end
                end
                hbpm_pkg::OP_SET_SPEED: begin
                    if (ch_ok && ({5'b0, r_limit} >= cmd.speed_request)) begin
                        res.accepted = 1'b1;
                        for (int c = 0; c < CHANNELS; c++) begin
                            if ({1'b0, cmd.motor_index} == 3'(c)) begin
                                n_speed[c] = {cmd.speed_request[hbpm_pkg::CNT_W-2:0], 1'b0};
                            end
                        end
                    end
                end
                hbpm_pkg::OP_SET_DIR: begin
                    if (ch_ok) begin
                        res.accepted = 1'b1;
                        for (int c = 0; c < CHANNELS; c++) begin
                            if ({1'b0, cmd.motor_index} == 3'(c)) begin
                                n_dir[c] = cmd.direction;
                            end
                        end
                    end
                end
                default: begin
                    res.accepted = 1'b0;
                end
            endcase
        end
        res.bridge_pins = n_pins;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gang   <= hbpm_pkg::GANG_SEPARATE;
            r_period <= hbpm_pkg::RESET_PERIOD;
            r_limit  <= hbpm_pkg::RESET_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hbpm_pkg::REG_GANG_MODE:   r_gang   <= i_cfg_data[1:0];
                hbpm_pkg::REG_PERIOD:      r_period <= i_cfg_data[hbpm_pkg::CNT_W-1:0];
                hbpm_pkg::REG_SPEED_LIMIT: r_limit  <= i_cfg_data[hbpm_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_count <= '0;
            r_pins  <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_speed[c] <= '0;
                r_dir[c]   <= 1'b0;
                r_cmp[c]   <= '0;
            end
        end else begin
            r_run   <= 1'b1;
            r_count <= n_count;
            r_pins  <= n_pins;
            for (int c = 0; c < CHANNELS; c++) begin
                r_speed[c] <= n_speed[c];
                r_dir[c]   <= n_dir[c];
                r_cmp[c]   <= n_cmp[c];
            end
        end
    end

    hbpm_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_data  (res),
        .o_free  (out_free),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

/* rtl/core/hbpm_out_stage.sv */
// ----------------------------------------------------------------------------
// H-bridge PWM motor driver result stage
// Result register that holds a transfer until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hbpm_out_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire hbpm_pkg::t_res i_data,
    output logic               o_free,
    hbpm_stream_if.source      o_res
);

    logic           r_valid;
    logic           n_valid;
    hbpm_pkg::t_res r_data;

    assign o_free = !r_valid || o_res.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_res.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_res.valid   = r_valid;
    assign o_res.payload = r_data;

endmodule

`default_nettype wire

/* rtl/core/hbpm_checker.sv */
// ----------------------------------------------------------------------------
// H-bridge PWM motor driver checker
// Port-level assertions on transfers and pin levels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "h_bridge_pwm_motor_driver_unit_defines.svh"

module hbpm_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic [1:0]                    i_in_op,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [hbpm_pkg::PINS_W-1:0]   i_out_pins,
    input wire logic                          i_out_accepted
);

    logic in_xfer;
    logic out_stall;
    logic rsv_xfer;
    logic pins_clash;

    assign in_xfer    = i_in_valid && i_in_ready;
    assign out_stall  = i_out_valid && !i_out_ready;
    assign rsv_xfer   = in_xfer && (i_in_op == hbpm_pkg::OP_RESERVED);
    assign pins_clash = |(i_out_pins & (i_out_pins >> 1) & 8'h55);

    `HBPM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid)
    `HBPM_ASSERT_NEXT(a_one_cycle_latency, i_clk, i_rst_n, in_xfer, i_out_valid)
    `HBPM_ASSERT_NOW(a_stall_blocks_input, i_clk, i_rst_n, out_stall, !i_in_ready)
    `HBPM_ASSERT_NEXT(a_reserved_rejected, i_clk, i_rst_n, rsv_xfer, !i_out_accepted)
    `HBPM_ASSERT_NOW(a_no_shoot_through, i_clk, i_rst_n, i_out_valid, !pins_clash)

endmodule

bind h_bridge_pwm_motor_driver_unit hbpm_checker u_hbpm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_cmd.valid),
    .i_in_ready     (i_cmd.ready),
    .i_in_op        (i_cmd.payload.operation),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_pins     (o_res.payload.bridge_pins),
    .i_out_accepted (o_res.payload.accepted)
);

`default_nettype wire
